// ===== design/bresenham_line_pixel_stepper_unit_defines.svh =====
// Assertion macros shared by the line stepper RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef BRESENHAM_LINE_PIXEL_STEPPER_UNIT_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_STEPPER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define BLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BLS_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define BLS_ASSERT(label, prop, msg)
`define BLS_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ===== design/bls_pkg.sv =====
package bls_pkg;

  localparam int COORD_BITS = 13;
  localparam int POS_BITS   = COORD_BITS + 1;
  localparam int DEC_BITS   = COORD_BITS + 4;
  localparam int PIX_BITS   = COORD_BITS + 2;
  localparam int SIDE_BITS  = COORD_BITS;
  localparam int ROW_BITS   = COORD_BITS - 1;
  localparam int SIDE_MAX   = 2 ** (COORD_BITS - 1);
  localparam int COLOR_BITS = 24;

  localparam int IN_DATA_BITS   = 4 * COORD_BITS + COLOR_BITS;
  localparam int TDATA_IN_BITS  = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = 2 * COORD_BITS + 1 + ROW_BITS + COLOR_BITS;
  localparam int TDATA_OUT_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_LSB   = 2;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - REG_IDX_LSB;

  localparam logic [REG_IDX_BITS-1:0] REG_RASTER_SIDE = REG_IDX_BITS'(0);
  localparam logic [SIDE_BITS-1:0]    RASTER_SIDE_RST = SIDE_BITS'(150);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef struct packed {
    logic [COLOR_BITS-1:0] color;
    logic [COORD_BITS-1:0] to_y;
    logic [COORD_BITS-1:0] to_x;
    logic [COORD_BITS-1:0] from_y;
    logic [COORD_BITS-1:0] from_x;
  } in_data_t;

  typedef struct packed {
    op_e      op;
    in_data_t data;
  } item_t;

  typedef struct packed {
    logic                  busy;
    logic [POS_BITS-1:0]   major_pos;
    logic [POS_BITS-1:0]   minor_pos;
    logic [POS_BITS-1:0]   major_len;
    logic [DEC_BITS-1:0]   decision;
    logic [DEC_BITS-1:0]   diag_step;
    logic [DEC_BITS-1:0]   straight_step;
    logic                  neg_x_dir;
    logic                  neg_y_dir;
    logic                  steep_swap;
    logic [COORD_BITS-1:0] origin_x;
    logic [COORD_BITS-1:0] origin_y;
    logic [COLOR_BITS-1:0] line_color;
  } state_t;

  typedef struct packed {
    logic                  valid_res;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  in_bounds;
    logic [ROW_BITS-1:0]   pixel_row;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] pixel_color;
    logic [ROW_BITS-1:0]   pixel_row;
    logic                  in_bounds;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COORD_BITS-1:0] pixel_x;
  } out_data_t;

endpackage

// ===== design/bls_step.sv =====
module bls_step (
  input  bls_pkg::item_t                  item_i,
  input  bls_pkg::state_t                 state_i,
  input  logic [bls_pkg::SIDE_BITS-1:0]   raster_side_i,
  output bls_pkg::state_t                 state_o,
  output bls_pkg::result_t                result_o
);
  import bls_pkg::*;

  logic [POS_BITS-1:0]        dx, dy, adx, ady, maj, mnr, major_inc;
  logic                       steep, dec_ge;
  state_t                     nxt;
  logic [POS_BITS-1:0]        off_x, off_y;
  logic signed [PIX_BITS-1:0] org_x, org_y, px, py, side_ext, row_full;
  logic [SIDE_BITS-1:0]       side;
  logic                       inb;

  // Setup of a new line: fold it into the first octant.
  always_comb begin
    dx = {item_i.data.to_x[COORD_BITS-1], item_i.data.to_x}
       - {item_i.data.from_x[COORD_BITS-1], item_i.data.from_x};
    dy = {item_i.data.to_y[COORD_BITS-1], item_i.data.to_y}
       - {item_i.data.from_y[COORD_BITS-1], item_i.data.from_y};
    adx   = dx[POS_BITS-1] ? -dx : dx;
    ady   = dy[POS_BITS-1] ? -dy : dy;
    steep = adx < ady;
    maj   = steep ? ady : adx;
    mnr   = steep ? adx : ady;
  end

  always_comb begin
    nxt       = state_i;
    dec_ge    = !state_i.decision[DEC_BITS-1];
    major_inc = state_i.major_pos + POS_BITS'(1);
    if (item_i.op == OP_START) begin
      nxt.origin_x      = item_i.data.from_x;
      nxt.origin_y      = item_i.data.from_y;
      nxt.line_color    = item_i.data.color;
      nxt.neg_x_dir     = dx[POS_BITS-1];
      nxt.neg_y_dir     = dy[POS_BITS-1];
      nxt.steep_swap    = steep;
      nxt.major_len     = maj;
      nxt.major_pos     = '0;
      nxt.minor_pos     = '0;
      nxt.diag_step     = DEC_BITS'({mnr, 1'b0}) - DEC_BITS'({maj, 1'b0});
      nxt.straight_step = DEC_BITS'({mnr, 1'b0});
      nxt.decision      = DEC_BITS'({mnr, 1'b0}) - DEC_BITS'(maj);
      nxt.busy          = maj != '0;
    end else if (state_i.busy) begin
      nxt.decision  = state_i.decision + (dec_ge ? state_i.diag_step : state_i.straight_step);
      nxt.minor_pos = state_i.minor_pos + POS_BITS'(dec_ge);
      nxt.major_pos = major_inc;
      nxt.busy      = major_inc < state_i.major_len;
    end
  end

  // Unfold the pixel from the updated position.
  always_comb begin
    off_x    = nxt.steep_swap ? nxt.minor_pos : nxt.major_pos;
    off_y    = nxt.steep_swap ? nxt.major_pos : nxt.minor_pos;
    org_x    = {{2{nxt.origin_x[COORD_BITS-1]}}, nxt.origin_x};
    org_y    = {{2{nxt.origin_y[COORD_BITS-1]}}, nxt.origin_y};
    px       = org_x + (nxt.neg_x_dir ? -$signed({1'b0, off_x}) : $signed({1'b0, off_x}));
    py       = org_y + (nxt.neg_y_dir ? -$signed({1'b0, off_y}) : $signed({1'b0, off_y}));
    side     = (raster_side_i > SIDE_BITS'(SIDE_MAX)) ? SIDE_BITS'(SIDE_MAX) : raster_side_i;
    side_ext = $signed({2'b00, side});
    inb      = !px[PIX_BITS-1] && !py[PIX_BITS-1] && (px < side_ext) && (py < side_ext);
    row_full = side_ext - PIX_BITS'(1) - py;

    result_o = '0;
    state_o  = state_i;
    if (item_i.op == OP_START || state_i.busy) begin
      state_o              = nxt;
      result_o.valid_res   = 1'b1;
      result_o.pixel_x     = px[COORD_BITS-1:0];
      result_o.pixel_y     = py[COORD_BITS-1:0];
      result_o.in_bounds   = inb;
      result_o.pixel_row   = inb ? row_full[ROW_BITS-1:0] : '0;
      result_o.pixel_color = nxt.line_color;
      result_o.last        = !nxt.busy;
    end
  end

endmodule

// ===== design/bresenham_line_pixel_stepper_unit.sv =====
// Line rasterizer: a start sets up a line and emits its first pixel; a step emits the next pixel,
// or a result with valid_res low when the line is idle. Items go through the input register and
// the result register. One item per cycle unless m_axis stalls; setup and step are combinational.
// Reset clears the line state, the valid flags and sets raster_side to 150.
`include "bresenham_line_pixel_stepper_unit_defines.svh"

module bresenham_line_pixel_stepper_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // from_x, from_y, to_x, to_y, color, zero pad
  input  logic [bls_pkg::TDATA_IN_BITS-1:0]   s_axis_tdata_i,
  // op
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // pixel_x, pixel_y, in_bounds, pixel_row, pixel_color, zero pad
  output logic [bls_pkg::TDATA_OUT_BITS-1:0]  m_axis_tdata_o,
  // valid_res
  output logic                                m_axis_tuser_o,
  output logic                                m_axis_tlast_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bls_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [bls_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [bls_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import bls_pkg::*;

  item_t                   in_d, in_q;
  logic                    in_vld_q, out_vld_q;
  state_t                  state_d, state_q;
  result_t                 res_d, res_q;
  logic [SIDE_BITS-1:0]    raster_q;
  logic                    out_ready, fire, cfg_wr;
  logic [REG_IDX_BITS-1:0] reg_idx;
  out_data_t               out_data;

  assign out_ready       = !out_vld_q || m_axis_tready_i;
  assign fire            = in_vld_q && out_ready;
  assign s_axis_tready_o = !in_vld_q || out_ready;

  assign in_d.op   = op_e'(s_axis_tuser_i);
  assign in_d.data = s_axis_tdata_i[IN_DATA_BITS-1:0];

  bls_step u_step (
    .item_i        (in_q),
    .state_i       (state_q),
    .raster_side_i (raster_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (out_ready) begin
        out_vld_q <= in_vld_q;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q <= in_d;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_BITS-1:REG_IDX_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == REG_RASTER_SIDE) ? APB_DATA_BITS'(raster_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raster_q <= RASTER_SIDE_RST;
    end else if (cfg_wr && reg_idx == REG_RASTER_SIDE) begin
      raster_q <= pwdata[SIDE_BITS-1:0];
    end
  end

  always_comb begin
    out_data.pixel_color = res_q.pixel_color;
    out_data.pixel_row   = res_q.pixel_row;
    out_data.in_bounds   = res_q.in_bounds;
    out_data.pixel_y     = res_q.pixel_y;
    out_data.pixel_x     = res_q.pixel_x;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = TDATA_OUT_BITS'(out_data);
  assign m_axis_tuser_o  = res_q.valid_res;
  assign m_axis_tlast_o  = res_q.last;

  `BLS_ASSERT(a_busy_pos_range, state_q.busy |-> (state_q.major_pos < state_q.major_len), "line active with position at or past its end")
  `BLS_ASSERT(a_step_emits_pixel, (fire && in_q.op == OP_STEP && state_q.busy) |=> (out_vld_q && res_q.valid_res), "step on an active line gave no pixel")
  `BLS_ASSERT_NEVER(a_idle_result_clean, out_vld_q && !res_q.valid_res && (res_q.in_bounds || res_q.last), "idle step result carries flags")
  `BLS_ASSERT_NEVER(a_row_zero_outside, out_vld_q && !res_q.in_bounds && (res_q.pixel_row != '0), "row nonzero for a pixel outside the raster")

endmodule

// ===== sim/bresenham_line_pixel_stepper_unit_tb.sv =====
module bresenham_line_pixel_stepper_unit_tb;
  import bls_pkg::*;

  localparam logic [APB_ADDR_BITS-1:0] SIDE_ADDR =
    APB_ADDR_BITS'(REG_RASTER_SIDE) << REG_IDX_LSB;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      s_axis_tvalid_i = 1'b0;
  logic                      s_axis_tready_o;
  logic [TDATA_IN_BITS-1:0]  s_axis_tdata_i = '0;
  logic                      s_axis_tuser_i = 1'b0;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i = 1'b0;
  logic [TDATA_OUT_BITS-1:0] m_axis_tdata_o;
  logic                      m_axis_tuser_o;
  logic                      m_axis_tlast_o;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0]  paddr = '0;
  logic [APB_DATA_BITS-1:0]  pwdata = '0;
  logic [APB_DATA_BITS-1:0]  prdata;
  logic                      pready;

  always #2 clk_i = ~clk_i;

  bresenham_line_pixel_stepper_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Items waiting to be driven and pixels waiting to come out.
  item_t   line_items[$];
  result_t expected_pixels[$];

  int queued_total = 0;
  int accepted_total = 0;
  int mismatches = 0;
  int starts_sent = 0;
  int steps_sent = 0;
  int pixels_checked = 0;
  int ends_seen = 0;
  int inb_seen = 0;

  logic calm = 1'b0;
  logic hold_start = 1'b0;
  int   hold_left = 0;

  // Shadow of the rasterizer state.
  logic [SIDE_BITS-1:0]  side_reg = RASTER_SIDE_RST;
  logic                  run_active = 1'b0;
  int                    along = 0;
  int                    across = 0;
  int                    run_len = 0;
  int                    err_acc = 0;
  int                    err_diag = 0;
  int                    err_flat = 0;
  logic                  mirror_x = 1'b0;
  logic                  mirror_y = 1'b0;
  logic                  axes_swapped = 1'b0;
  logic [COORD_BITS-1:0] anchor_x = '0;
  logic [COORD_BITS-1:0] anchor_y = '0;
  logic [COLOR_BITS-1:0] run_rgb = '0;

  item_t                    on_bus;
  logic [TDATA_IN_BITS-1:0] in_word;
  result_t                  want;
  out_data_t                got;

  function automatic int as_coord(logic [COORD_BITS-1:0] v);
    return int'($signed(v));
  endfunction

  function automatic int clamped_side();
    return (side_reg > SIDE_MAX) ? SIDE_MAX : int'(side_reg);
  endfunction

  // Unfold the current octant position back into raster coordinates.
  function automatic result_t line_pixel(logic at_end);
    int      off_x, off_y, px, py, lim;
    logic    hit;
    result_t r;
    off_x = axes_swapped ? across : along;
    off_y = axes_swapped ? along : across;
    px = as_coord(anchor_x) + (mirror_x ? -off_x : off_x);
    py = as_coord(anchor_y) + (mirror_y ? -off_y : off_y);
    lim = clamped_side();
    hit = (px >= 0) && (py >= 0) && (px < lim) && (py < lim);
    r.valid_res   = 1'b1;
    r.pixel_x     = COORD_BITS'(px);
    r.pixel_y     = COORD_BITS'(py);
    r.in_bounds   = hit;
    r.pixel_row   = hit ? ROW_BITS'(lim - 1 - py) : '0;
    r.pixel_color = run_rgb;
    r.last        = at_end;
    return r;
  endfunction

  function automatic void rasterize_item(item_t it);
    int      fx, fy, dx, dy, mj, mn;
    result_t blank;
    blank = '0;
    if (it.op == OP_START) begin
      fx = as_coord(it.data.from_x);
      fy = as_coord(it.data.from_y);
      dx = as_coord(it.data.to_x) - fx;
      dy = as_coord(it.data.to_y) - fy;
      anchor_x = it.data.from_x;
      anchor_y = it.data.from_y;
      run_rgb = it.data.color;
      mirror_x = dx < 0;
      mirror_y = dy < 0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      axes_swapped = dx < dy;
      mj = axes_swapped ? dy : dx;
      mn = axes_swapped ? dx : dy;
      run_len = mj;
      along = 0;
      across = 0;
      err_diag = 2 * (mn - mj);
      err_flat = 2 * mn;
      err_acc = 2 * mn - mj;
      run_active = mj > 0;
      expected_pixels.push_back(line_pixel(mj == 0));
    end else if (!run_active) begin
      expected_pixels.push_back(blank);
    end else begin
      if (err_acc >= 0) begin
        err_acc += err_diag;
        across++;
      end else begin
        err_acc += err_flat;
      end
      along++;
      if (along >= run_len) run_active = 1'b0;
      expected_pixels.push_back(line_pixel(!run_active));
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
    mismatches++;
    $display("MISMATCH result %0d: %s got %0h expected %0h", pixels_checked, what, seen, wanted);
  endtask

  function automatic void queue_item(op_e op, int fx, int fy, int tx, int ty,
                                     logic [COLOR_BITS-1:0] rgb);
    item_t it;
    it.op = op;
    it.data.from_x = COORD_BITS'(fx);
    it.data.from_y = COORD_BITS'(fy);
    it.data.to_x = COORD_BITS'(tx);
    it.data.to_y = COORD_BITS'(ty);
    it.data.color = rgb;
    line_items.push_back(it);
    queued_total++;
  endfunction

  function automatic void queue_start(int fx, int fy, int tx, int ty, logic [COLOR_BITS-1:0] rgb);
    queue_item(OP_START, fx, fy, tx, ty, rgb);
  endfunction

  // Step items carry random payload; the block ignores it.
  function automatic void queue_steps(int n);
    for (int i = 0; i < n; i++)
      queue_item(OP_STEP, $urandom, $urandom, $urandom, $urandom, COLOR_BITS'($urandom));
  endfunction

  // Endpoint at a given offset, mirrored back when it would leave the coordinate range.
  function automatic int reach(int from, int d);
    int t;
    t = from + d;
    if (t > 4095 || t < -4096) t = from - d;
    return t;
  endfunction

  function automatic int pick_coord(int regime, int lim);
    int v;
    case (regime)
      0: begin
        v = int'($urandom_range(0, lim + 6)) - 3;
        if (v > 4095) v = 4095;
      end
      1: v = as_coord(COORD_BITS'($urandom));
      2: v = $urandom_range(0, 1) ? 4095 - int'($urandom_range(0, 4))
                                  : -4096 + int'($urandom_range(0, 4));
      default: v = int'($urandom_range(0, 16)) - 8;
    endcase
    return v;
  endfunction

  function automatic void queue_random_lines(int budget);
    int stop, fx, fy, tx, ty, span, n, regime, lim, pick;
    stop = queued_total + budget;
    lim = clamped_side();
    while (queued_total < stop) begin
      if ($urandom_range(0, 99) < 8) begin
        queue_item(op_e'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                   COLOR_BITS'($urandom));
      end else begin
        regime = $urandom_range(0, 3);
        fx = pick_coord(regime, lim);
        fy = pick_coord(regime, lim);
        span = ($urandom_range(0, 9) == 0) ? 40 : 12;
        tx = reach(fx, int'($urandom_range(0, 2 * span)) - span);
        ty = reach(fy, int'($urandom_range(0, 2 * span)) - span);
        n = (tx > fx) ? tx - fx : fx - tx;
        if (((ty > fy) ? ty - fy : fy - ty) > n) n = (ty > fy) ? ty - fy : fy - ty;
        queue_start(fx, fy, tx, ty, COLOR_BITS'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 15) n = $urandom_range(0, n);
        else if (pick < 25) n += $urandom_range(1, 3);
        queue_steps(n);
      end
    end
  endfunction

  task automatic apb_write(input logic [APB_DATA_BITS-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SIDE_ADDR;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    side_reg = value[SIDE_BITS-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= SIDE_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== APB_DATA_BITS'(side_reg))
      report_mismatch("raster_side readback", prdata, APB_DATA_BITS'(side_reg));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (accepted_total != queued_total || expected_pixels.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Input side: present the next pending item, or idle at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        rasterize_item(on_bus);
        accepted_total++;
        if (on_bus.op == OP_START) starts_sent++;
        else steps_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (line_items.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
          on_bus = line_items.pop_front();
          in_word = '0;
          in_word[IN_DATA_BITS-1:0] = on_bus.data;
          s_axis_tdata_i <= in_word;
          s_axis_tuser_i <= on_bus.op;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver stall, counted down on its own.
  always @(posedge clk_i) begin
    if (hold_start) hold_left <= 150;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Output side: check each accepted transaction against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[OUT_DATA_BITS-1:0];
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata_o[31:0], '0);
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tuser_o !== want.valid_res)
            report_mismatch("valid_res", m_axis_tuser_o, want.valid_res);
          if (got.pixel_x !== want.pixel_x)
            report_mismatch("pixel_x", got.pixel_x, want.pixel_x);
          if (got.pixel_y !== want.pixel_y)
            report_mismatch("pixel_y", got.pixel_y, want.pixel_y);
          if (got.in_bounds !== want.in_bounds)
            report_mismatch("in_bounds", got.in_bounds, want.in_bounds);
          if (got.pixel_row !== want.pixel_row)
            report_mismatch("pixel_row", got.pixel_row, want.pixel_row);
          if (got.pixel_color !== want.pixel_color)
            report_mismatch("pixel_color", got.pixel_color, want.pixel_color);
          if (m_axis_tlast_o !== want.last)
            report_mismatch("last", m_axis_tlast_o, want.last);
          if (want.valid_res && want.last) ends_seen++;
          if (want.in_bounds) inb_seen++;
        end
        pixels_checked++;
      end
      m_axis_tready_i <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 27);
    end
  end

  initial begin
    #2000000;
    $display("bresenham_line_pixel_stepper_unit verification failed");
    $finish;
  end

  initial begin
    logic [APB_DATA_BITS-1:0] side_val;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_read_check();

    // Directed lines at the reset raster size.
    queue_steps(1);
    queue_start(5, 5, 5, 5, 24'hFFFFFF);
    queue_steps(1);
    queue_start(0, 0, 4, 1, 24'h000000);
    queue_steps(4);
    // A steep descending line, dropped halfway by the next start.
    queue_start(20, 20, 19, 16, 24'h123456);
    queue_steps(2);
    queue_start(-4096, -4096, 4095, 4095, 24'h800001);
    queue_steps(2);
    queue_start(4095, 4095, -4096, 4095, 24'h00FF00);
    queue_steps(1);
    // Crosses the right edge of the raster and steps twice past its end.
    queue_start(149, 149, 150, 147, 24'h0000FF);
    queue_steps(4);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: side_val = 1;
        1: side_val = 0;
        2: side_val = 8191;
        3: side_val = SIDE_MAX;
        4: side_val = $urandom_range(2, 4095);
        default: side_val = 37;
      endcase
      apb_write(side_val);
      apb_read_check();
      calm <= (p == 2);
      queue_random_lines(85);
      if (p == 1) begin
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
      // One line of the longest span, stepped a short way from its start.
      if (p == 3) begin
        queue_start(-4096, -4096, 4094, 4095, 24'hA5C3F0);
        queue_steps(40);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("Drove %0d line starts and %0d step transactions over 7 raster sizes, %0d results checked.",
             starts_sent, steps_sent, pixels_checked);
    $display("Saw %0d line ends and %0d in-bounds pixels, with idle steps, restarts and stalls.",
             ends_seen, inb_seen);
    if (mismatches == 0) begin
      $display("bresenham_line_pixel_stepper_unit verification clean");
    end else begin
      $display("bresenham_line_pixel_stepper_unit verification failed");
    end
    $finish;
  end

endmodule
